### rtl/rrtc_pkg.sv
// Package for the request retry/timeout controller.
// Holds field widths, register indexes, status codes and shared types.
// No dependencies.
package rrtc_pkg;

	// Field widths
	localparam int TIME_W    = 32;
	localparam int LIMIT_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int INDEX_W   = 3;
	localparam int CFG_DATA_W = 32;

	// Attempt counter width; it wraps at 2^ATTEMPT_WIDTH
	localparam int ATTEMPT_WIDTH = 8;
	// Compare width that covers both the counter and the limit register
	localparam int CMP_W = (ATTEMPT_WIDTH > LIMIT_W) ? ATTEMPT_WIDTH : LIMIT_W;

	typedef logic [TIME_W-1:0]        time_ms_t;
	typedef logic [LIMIT_W-1:0]       limit_t;
	typedef logic [ATTEMPT_WIDTH-1:0] attempt_t;
	typedef logic [STATUS_W-1:0]      status_t;
	typedef logic [INDEX_W-1:0]       cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	// Result status codes
	localparam status_t STATUS_RUNNING  = 2'd0;
	localparam status_t STATUS_SUCCESS  = 2'd1;
	localparam status_t STATUS_FAILURE  = 2'd2;
	localparam status_t STATUS_RESERVED = 2'd3;

	// Register indexes
	localparam cfg_index_t REG_TIMEOUT        = 3'd0;
	localparam cfg_index_t REG_RESEND_PERIOD  = 3'd1;
	localparam cfg_index_t REG_MAX_ATTEMPTS   = 3'd2;
	localparam cfg_index_t REG_RESEND_ENABLE  = 3'd3;
	localparam cfg_index_t REG_SUCCESS_ENABLE = 3'd4;

	// Register reset values
	localparam time_ms_t RST_TIMEOUT        = 32'd1000;
	localparam time_ms_t RST_RESEND_PERIOD  = 32'd100;
	localparam limit_t   RST_MAX_ATTEMPTS   = 8'd3;
	localparam logic     RST_RESEND_ENABLE  = 1'b0;
	localparam logic     RST_SUCCESS_ENABLE = 1'b1;

	// Configuration register set
	typedef struct packed {
		time_ms_t timeout_ms;
		time_ms_t resend_period_ms;
		limit_t   max_attempts;
		logic     resend_enable;
		logic     success_check_enable;
	} cfg_t;

	// Engine status toward the top level
	typedef struct packed {
		logic s1_valid;   // item held in the input register
		logic advance;    // input register moves to the result register
		logic waiting;    // an attempt is in flight
		logic count_zero; // attempt counter is clear
		logic done;       // item being processed ends the request
	} eng_st_t;

	// Wrap-aware "now is at or past start + delay"
	function automatic logic elapsed(time_ms_t now, time_ms_t start, time_ms_t delay);
		time_ms_t diff;
		diff = now - (start + delay);
		return ~diff[TIME_W-1];
	endfunction

endpackage

### rtl/rrtc_if.sv
// Channel interfaces of the request retry/timeout controller: poll input,
// result output and configuration write. Depends on rrtc_pkg.

interface rrtc_poll_if import rrtc_pkg::*; ();
	logic     valid;
	logic     ready;
	time_ms_t now_ms;
	logic     no_response_yet;
	logic     response_ok;

	modport source (output valid, output now_ms, output no_response_yet,
		output response_ok, input ready);
	modport sink (input valid, input now_ms, input no_response_yet,
		input response_ok, output ready);
endinterface

interface rrtc_result_if import rrtc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    send_request;
	status_t status;

	modport source (output valid, output send_request, output status, input ready);
	modport sink (input valid, input send_request, input status, output ready);
endinterface

interface rrtc_cfg_if import rrtc_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/request_retry_timeout_controller.sv
// Request retry/timeout controller, top level.
// A transferred poll sits in the input register, then in the result register.
// Throughput: one poll per cycle while results are taken; the input and result
// registers decouple the sides: one more poll is taken while a result is held.
// Reset (arst_n low): registers return to 1000/100/3/0/1, the block is idle
// with a cleared attempt count, and both pipeline registers are empty.
module request_retry_timeout_controller import rrtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rrtc_poll_if.sink     poll,
	rrtc_result_if.source result,
	rrtc_cfg_if.sink      cfg
);

	cfg_t    regs;
	eng_st_t st;

	rrtc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rrtc_poll_engine u_poll_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.result (result),
		.regs   (regs),
		.st     (st)
	);

	// A transferred poll lands in the input register
	a_poll_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(poll.valid && poll.ready) |=> st.s1_valid)
		else $error("accepted poll not held in input register");

	// An idle poll that is processed starts an attempt
	a_idle_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(st.advance && !st.waiting) |=> st.waiting)
		else $error("idle poll did not start an attempt");

	// Ending a request goes idle with a cleared count
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st.advance && st.done) |=> (!st.waiting && st.count_zero))
		else $error("finished request left state behind");

	// The reserved status code never leaves the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status != STATUS_RESERVED))
		else $error("reserved status on result channel");

endmodule

### rtl/rrtc_cfg_regs.sv
// Configuration register file of the request retry/timeout controller.
// Depends on rrtc_pkg and rrtc_cfg_if.
module rrtc_cfg_regs import rrtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rrtc_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;
	logic wr_en;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;

	// Register decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.timeout_ms           <= RST_TIMEOUT;
			regs_q.resend_period_ms     <= RST_RESEND_PERIOD;
			regs_q.max_attempts         <= RST_MAX_ATTEMPTS;
			regs_q.resend_enable        <= RST_RESEND_ENABLE;
			regs_q.success_check_enable <= RST_SUCCESS_ENABLE;
		end else if (wr_en) begin
			unique case (cfg.index)
				REG_TIMEOUT:        regs_q.timeout_ms           <= cfg.data[TIME_W-1:0];
				REG_RESEND_PERIOD:  regs_q.resend_period_ms     <= cfg.data[TIME_W-1:0];
				REG_MAX_ATTEMPTS:   regs_q.max_attempts         <= cfg.data[LIMIT_W-1:0];
				REG_RESEND_ENABLE:  regs_q.resend_enable        <= cfg.data[0];
				REG_SUCCESS_ENABLE: regs_q.success_check_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

### rtl/rrtc_poll_engine.sv
// Poll datapath: input register, one pass of retry/timeout logic with the
// attempt state, and the result register. Depends on rrtc_pkg and the
// poll/result interfaces.
module rrtc_poll_engine import rrtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rrtc_poll_if.sink     poll,
	rrtc_result_if.source result,
	input  cfg_t          regs,
	output eng_st_t       st
);

	// Input register
	logic     valid_s1;
	time_ms_t now_s1;
	logic     no_resp_s1;
	logic     ok_s1;

	// Result register
	logic     valid_s2;
	logic     send_s2;
	status_t  status_s2;

	// Attempt state
	logic     waiting_q;
	time_ms_t attempt_start_q;
	time_ms_t last_send_q;
	attempt_t attempt_count_q;

	// Next state and result of the item in the input register
	logic     waiting_n;
	time_ms_t attempt_start_n;
	time_ms_t last_send_n;
	attempt_t attempt_count_n;
	logic     send_n;
	status_t  status_n;
	logic     resend_hit;
	logic     success_hit;
	logic     timeout_hit;
	attempt_t count_inc;
	logic     advance;
	logic     s2_free;

	assign s2_free    = !valid_s2 || result.ready;
	assign advance    = valid_s1 && s2_free;
	assign poll.ready = !valid_s1 || advance;

	// Input register: take a transfer whenever the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			now_s1     <= poll.now_ms;
			no_resp_s1 <= poll.no_response_yet;
			ok_s1      <= poll.response_ok;
		end
	end

	// Time checks against the current attempt
	assign resend_hit = regs.resend_enable && no_resp_s1 &&
		elapsed(now_s1, last_send_q, regs.resend_period_ms) &&
		!elapsed(now_s1, attempt_start_q, regs.timeout_ms - regs.resend_period_ms);
	assign success_hit = regs.success_check_enable && ok_s1;
	assign timeout_hit = elapsed(now_s1, attempt_start_q, regs.timeout_ms);
	assign count_inc   = attempt_count_q + attempt_t'(1);

	// One poll: send when idle, else resend / success / timeout in order
	always_comb begin
		waiting_n       = waiting_q;
		attempt_start_n = attempt_start_q;
		last_send_n     = last_send_q;
		attempt_count_n = attempt_count_q;
		send_n          = 1'b0;
		status_n        = STATUS_RUNNING;
		if (!waiting_q) begin
			send_n          = 1'b1;
			attempt_start_n = now_s1;
			last_send_n     = now_s1;
			waiting_n       = 1'b1;
		end else begin
			if (resend_hit) begin
				send_n      = 1'b1;
				last_send_n = now_s1;
			end
			if (success_hit) begin
				waiting_n       = 1'b0;
				attempt_count_n = '0;
				status_n        = STATUS_SUCCESS;
			end else if (timeout_hit) begin
				waiting_n = 1'b0;
				if (CMP_W'(count_inc) >= CMP_W'(regs.max_attempts)) begin
					attempt_count_n = '0;
					status_n        = STATUS_FAILURE;
				end else begin
					attempt_count_n = count_inc;
				end
			end
		end
	end

	// Attempt state moves with each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q       <= 1'b0;
			attempt_start_q <= '0;
			last_send_q     <= '0;
			attempt_count_q <= '0;
		end else if (advance) begin
			waiting_q       <= waiting_n;
			attempt_start_q <= attempt_start_n;
			last_send_q     <= last_send_n;
			attempt_count_q <= attempt_count_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			send_s2   <= send_n;
			status_s2 <= status_n;
		end
	end

	assign result.valid        = valid_s2;
	assign result.send_request = send_s2;
	assign result.status       = status_s2;

	assign st.s1_valid   = valid_s1;
	assign st.advance    = advance;
	assign st.waiting    = waiting_q;
	assign st.count_zero = (attempt_count_q == '0);
	assign st.done       = (status_n != STATUS_RUNNING);

endmodule

### bench/tb_request_retry_timeout_controller.sv
// Testbench for request_retry_timeout_controller: sends polls and register writes
// over the channel interfaces and checks every result against an in-bench model
// of the retry, resend and timeout rules. Depends on rrtc_pkg and rrtc_if.
`timescale 1ns / 100ps

module tb_request_retry_timeout_controller;
	import rrtc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_PRINTED     = 40;
	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_POLLS     = 90;
	localparam cfg_index_t FIRST_UNUSED_INDEX = REG_SUCCESS_ENABLE + 1'b1;
	localparam cfg_index_t LAST_INDEX         = '1;

	typedef struct packed {
		logic    send_request;
		status_t status;
	} outcome_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rrtc_poll_if   poll();
	rrtc_result_if result();
	rrtc_cfg_if    cfg();

	request_retry_timeout_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.result (result),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// Model of the controller: register copy and attempt state
	cfg_t     shadow_cfg  = '{RST_TIMEOUT, RST_RESEND_PERIOD, RST_MAX_ATTEMPTS,
		RST_RESEND_ENABLE, RST_SUCCESS_ENABLE};
	logic     in_attempt  = 1'b0;
	time_ms_t attempt_t0  = '0;
	time_ms_t last_tx     = '0;
	attempt_t tries       = '0;

	outcome_t    pending_outcomes[$];
	outcome_t    due_outcome;
	int          error_count = 0;
	int          idle_cycles = 0;
	logic        hold_off    = 1'b0;
	stall_mode_t stall_mode  = STALL_NONE;
	logic [5:0]  stall_count = '0;
	bit          sender_gaps = 1'b0;
	int          burst_left  = 0;
	time_ms_t    clock_ms    = '0;

	// True once now has reached from + span, modulo 2^32
	function automatic logic deadline_passed(time_ms_t now, time_ms_t from, time_ms_t span);
		time_ms_t d;
		d = now - from - span;
		return $signed(d) >= 0;
	endfunction

	// Next result of the controller for one poll; updates the attempt state
	function automatic outcome_t predict_outcome(time_ms_t now, logic no_resp, logic ok);
		outcome_t o;
		logic     finished;
		o.send_request = 1'b0;
		o.status       = STATUS_RUNNING;
		finished       = 1'b0;
		if (!in_attempt) begin
			o.send_request = 1'b1;
			attempt_t0     = now;
			last_tx        = now;
			in_attempt     = 1'b1;
		end else begin
			// resend only inside the window that closes one period before timeout
			if (shadow_cfg.resend_enable && no_resp &&
				deadline_passed(now, last_tx, shadow_cfg.resend_period_ms) &&
				!deadline_passed(now, attempt_t0,
					shadow_cfg.timeout_ms - shadow_cfg.resend_period_ms)) begin
				o.send_request = 1'b1;
				last_tx        = now;
			end
			if (shadow_cfg.success_check_enable && ok) begin
				in_attempt = 1'b0;
				tries      = '0;
				o.status   = STATUS_SUCCESS;
				finished   = 1'b1;
			end
			if (!finished && deadline_passed(now, attempt_t0, shadow_cfg.timeout_ms)) begin
				tries      = tries + 1'b1;
				in_attempt = 1'b0;
				if (tries >= shadow_cfg.max_attempts) begin
					tries    = '0;
					o.status = STATUS_FAILURE;
				end
			end
		end
		return o;
	endfunction

	task automatic flag_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Result check first, then predict the poll taken on the same edge
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("result transfer with no poll outstanding");
			end else begin
				due_outcome = pending_outcomes.pop_front();
				if (result.send_request !== due_outcome.send_request)
					flag_mismatch($sformatf("send_request %b, expected %b",
						result.send_request, due_outcome.send_request));
				if (result.status !== due_outcome.status)
					flag_mismatch($sformatf("status %0d, expected %0d",
						result.status, due_outcome.status));
			end
		end
		if (arst_n && poll.valid && poll.ready)
			pending_outcomes.push_back(predict_outcome(poll.now_ms,
				poll.no_response_yet, poll.response_ok));
	end

	// Result side stalls
	always @(posedge clk) begin
		stall_count <= stall_count + 1'b1;
		if (hold_off) begin
			result.ready <= 1'b0;
		end else begin
			case (stall_mode)
				STALL_NONE:   result.ready <= 1'b1;
				STALL_RANDOM: result.ready <= ($urandom_range(0, 99) >= 35);
				default:      result.ready <= !(stall_count[5:3] == 3'b101 ||
					stall_count[1:0] == 2'b11);
			endcase
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((poll.valid && poll.ready) || (result.valid && result.ready) ||
			(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired at %0t", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	// One poll transfer; idles in bursts when gaps are on
	task automatic send_poll(input time_ms_t now, input logic no_resp, input logic ok);
		poll.valid           <= 1'b1;
		poll.now_ms          <= now;
		poll.no_response_yet <= no_resp;
		poll.response_ok     <= ok;
		do @(posedge clk); while (!poll.ready);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				poll.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic close_phase();
		poll.valid <= 1'b0;
		wait_drained();
	endtask

	// One register transfer; valid stays up for the next write
	task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_TIMEOUT:        shadow_cfg.timeout_ms           = value;
			REG_RESEND_PERIOD:  shadow_cfg.resend_period_ms     = value;
			REG_MAX_ATTEMPTS:   shadow_cfg.max_attempts         = value[LIMIT_W-1:0];
			REG_RESEND_ENABLE:  shadow_cfg.resend_enable        = value[0];
			REG_SUCCESS_ENABLE: shadow_cfg.success_check_enable = value[0];
			default: ;
		endcase
	endtask

	// Full register set plus one write to an unused index; upper bits of the
	// narrow registers carry junk that must be dropped
	task automatic program_regs(input time_ms_t to, input time_ms_t period, input limit_t lim,
		input logic resend_en, input logic success_en);
		cfg_data_t junk;
		junk = $urandom;
		write_reg(REG_TIMEOUT, to);
		write_reg(REG_RESEND_PERIOD, period);
		write_reg(REG_MAX_ATTEMPTS, {junk[CFG_DATA_W-1:LIMIT_W], lim});
		junk = $urandom;
		write_reg(REG_RESEND_ENABLE, {junk[CFG_DATA_W-1:1], resend_en});
		junk = $urandom;
		write_reg(REG_SUCCESS_ENABLE, {junk[CFG_DATA_W-1:1], success_en});
		write_reg(cfg_index_t'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)), $urandom);
		cfg.valid <= 1'b0;
	endtask

	// Random polls around a running clock, with noise and jumps
	task automatic run_polls(input int count, input int step_max, input int nr_pct,
		input int ok_pct);
		time_ms_t now;
		for (int i = 0; i < count; i++) begin
			clock_ms += $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < 3)
				clock_ms += $urandom;
			now = ($urandom_range(0, 99) < 5) ? time_ms_t'($urandom) : clock_ms;
			send_poll(now, $urandom_range(0, 99) < nr_pct, $urandom_range(0, 99) < ok_pct);
		end
		close_phase();
	endtask

	// Reset register values: one timeout of 1000 ms, a new attempt, then success
	task automatic test_defaults_after_reset();
		stall_mode  <= STALL_RANDOM;
		sender_gaps = 1'b0;
		send_poll(32'd0, 1'b0, 1'b0);
		send_poll(32'd999, 1'b1, 1'b0);
		send_poll(32'd1000, 1'b0, 1'b0);
		send_poll(32'd1000, 1'b1, 1'b1);
		send_poll(32'd1500, 1'b0, 1'b1);
		close_phase();
	endtask

	task automatic test_special_cases();
		// resend across the time wrap, resend with success, zero limit, closed window
		program_regs(32'd50, 32'd10, 8'd0, 1'b1, 1'b1);
		send_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
		send_poll(32'hFFFF_FFFA, 1'b1, 1'b0);
		send_poll(32'd4, 1'b1, 1'b1);
		send_poll(32'd100, 1'b0, 1'b0);
		send_poll(32'd150, 1'b0, 1'b0);
		send_poll(32'd200, 1'b1, 1'b0);
		send_poll(32'd245, 1'b1, 1'b0);
		send_poll(32'd250, 1'b1, 1'b0);
		close_phase();
		// success check off: only the timeout ends the attempt
		program_regs(32'd50, 32'd10, 8'd255, 1'b0, 1'b0);
		send_poll(32'd300, 1'b0, 1'b1);
		send_poll(32'd310, 1'b0, 1'b1);
		send_poll(32'd350, 1'b0, 1'b1);
		close_phase();
		// limit lowered to the running count
		program_regs(32'd50, 32'd10, 8'd1, 1'b0, 1'b0);
		send_poll(32'd360, 1'b0, 1'b0);
		send_poll(32'd410, 1'b1, 1'b1);
		close_phase();
	endtask

	task automatic test_random_settings();
		time_ms_t to;
		time_ms_t period;
		int       step_max;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			stall_mode  <= stall_mode_t'(p % 3);
			sender_gaps = (p % 5 != 4);
			clock_ms    = (p % 2) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
			case (p % 4)
				0: begin
					to       = $urandom_range(20, 120);
					period   = $urandom_range(1, to / 3);
					step_max = to / 8 + 1;
					program_regs(to, period, limit_t'($urandom_range(1, 5)), 1'b1, 1'b1);
				end
				1: begin
					// period at or above the timeout: the window bound wraps or is zero
					to       = $urandom_range(10, 60);
					period   = $urandom_range(to, 200);
					step_max = to / 6 + 1;
					program_regs(to, period, limit_t'($urandom_range(0, 3)), 1'b1,
						1'($urandom_range(0, 1)));
				end
				2: begin
					to       = $urandom;
					period   = $urandom;
					step_max = 1000;
					program_regs(to, period, limit_t'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
				default: begin
					to       = $urandom_range(0, 30);
					period   = $urandom_range(0, 10);
					step_max = 6;
					program_regs(to, period, limit_t'($urandom_range(200, 255)), 1'b1, 1'b0);
				end
			endcase
			run_polls(PHASE_POLLS, step_max, 70, 6);
		end
	endtask

	task automatic test_extreme_settings();
		stall_mode  <= STALL_PATTERN;
		sender_gaps = 1'b1;
		program_regs('0, '0, '0, 1'b0, 1'b0);
		run_polls(40, 20, 50, 50);
		program_regs('1, '1, '1, 1'b1, 1'b1);
		run_polls(40, 20, 50, 10);
	endtask

	// Result side held off while polls keep coming, so the block backs up
	task automatic test_backpressure_fill();
		stall_mode  <= STALL_NONE;
		sender_gaps = 1'b0;
		program_regs(32'd40, 32'd5, 8'd2, 1'b1, 1'b1);
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		run_polls(60, 6, 70, 8);
	endtask

	initial begin
		poll.valid           = 1'b0;
		poll.now_ms          = '0;
		poll.no_response_yet = 1'b0;
		poll.response_ok     = 1'b0;
		cfg.valid            = 1'b0;
		cfg.index            = REG_TIMEOUT;
		cfg.data             = '0;
		result.ready         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_defaults_after_reset();
		test_special_cases();
		test_random_settings();
		test_extreme_settings();
		test_backpressure_fill();

		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
rtl/rrtc_pkg.sv
rtl/rrtc_if.sv
rtl/rrtc_cfg_regs.sv
rtl/rrtc_poll_engine.sv
rtl/request_retry_timeout_controller.sv
bench/tb_request_retry_timeout_controller.sv
